/* rtl/core/pufact_pkg.sv */
// shared constants and factorial table for the permutation unranking pipeline
`default_nettype none

package pufact_pkg;

  // field widths
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned RANK_W  = 19;
  localparam int unsigned DIGIT_W = 4;

  // default number of elements
  localparam int unsigned MAX_ELEMENTS_DEF = 9;

  // i! for i in 0..9, zero for codes without meaning
  function automatic logic [RANK_W-1:0] fact_f(input logic [LEN_W-1:0] idx);
    logic [RANK_W-1:0] res;
    res = '0;
    case (idx)
      4'd0: res = 19'd1;
      4'd1: res = 19'd1;
      4'd2: res = 19'd2;
      4'd3: res = 19'd6;
      4'd4: res = 19'd24;
      4'd5: res = 19'd120;
      4'd6: res = 19'd720;
      4'd7: res = 19'd5040;
      4'd8: res = 19'd40320;
      4'd9: res = 19'd362880;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/permutation_unrank_factoradic.sv */
// k-th lexicographic permutation of 1..n, one digit per pipeline stage
//
// Usage: the input channel (in_valid_i / in_ready_o) carries a beat with a
// length perm_length_i (1..MaxElements) and a one-based rank rank_index_i.
// The output channel (out_valid_o / out_ready_i) returns one beat per input
// beat, in order: perm_digits_o holds the permutation, 4 bits per digit with
// the first digit in the lowest nibble and unused nibbles zero. rank_error_o
// is set, with perm_digits_o zero, when the length or rank is out of range.
// The pipeline has one check/setup stage, then one stage
// per digit position, each doing a compare against the multiples of the
// remaining factorial and removing the chosen digit from the pool.
// Throughput is one beat per cycle; a beat enters whenever its stage is free.
// When the receiver stalls, beats pile up into empty stages behind the
// output register, and in_ready_o falls only once every stage is full.
// Reset clears all stage valid bits; data registers are not reset.
`default_nettype none

module permutation_unrank_factoradic #(
  parameter int unsigned MaxElements = pufact_pkg::MAX_ELEMENTS_DEF
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     rst_ni,
  input  wire logic                                     in_valid_i,
  output logic                                          in_ready_o,
  input  wire logic [pufact_pkg::LEN_W-1:0]             perm_length_i,
  input  wire logic [pufact_pkg::RANK_W-1:0]            rank_index_i,
  output logic                                          out_valid_o,
  input  wire logic                                     out_ready_i,
  output logic [pufact_pkg::DIGIT_W*MaxElements-1:0]    perm_digits_o,
  output logic                                          rank_error_o
);

  localparam int unsigned LenW   = pufact_pkg::LEN_W;
  localparam int unsigned RankW  = pufact_pkg::RANK_W;
  localparam int unsigned DigitW = pufact_pkg::DIGIT_W;
  localparam int unsigned IdxW   = (MaxElements > 1) ? $clog2(MaxElements) : 1;

  typedef logic [MaxElements-1:0][DigitW-1:0] nib_vec_t;

  // stage registers, stage 0 is the setup stage
  logic [MaxElements:0]   vld_q;
  logic [MaxElements+1:0] stg_rdy;
  logic [LenW-1:0]        len_q  [MaxElements+1];
  logic [RankW-1:0]       rank_q [MaxElements+1];
  logic                   err_q  [MaxElements+1];
  nib_vec_t               pool_q [MaxElements+1];
  nib_vec_t               perm_q [MaxElements+1];

  // backpressure chain: a stage takes a beat when empty or when it moves on
  assign stg_rdy[MaxElements+1] = out_ready_i;
  for (genvar s = 0; s <= MaxElements; s++) begin : g_rdy
    assign stg_rdy[s] = !vld_q[s] || stg_rdy[s+1];
  end

  assign in_ready_o = stg_rdy[0];

  // setup stage: range check, rank minus one, identity pool
  logic            in_err;
  nib_vec_t        pool_init;
  logic [RankW-1:0] fact_n;

  always_comb begin
    fact_n = pufact_pkg::fact_f(perm_length_i);
    in_err = (perm_length_i == '0) || (perm_length_i > LenW'(MaxElements)) ||
             (rank_index_i == '0) || (rank_index_i > fact_n);
    for (int j = 0; j < MaxElements; j++) begin
      pool_init[j] = DigitW'(j + 1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (stg_rdy[0]) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && stg_rdy[0]) begin
      len_q[0]  <= perm_length_i;
      rank_q[0] <= rank_index_i - RankW'(1);
      err_q[0]  <= in_err;
      pool_q[0] <= pool_init;
      perm_q[0] <= '0;
    end
  end

  // digit stages: stage i picks the digit for position i
  for (genvar i = 0; i < MaxElements; i++) begin : g_dig
    logic             active;
    logic [LenW-1:0]  left;
    logic [RankW-1:0] fsel;
    logic [RankW-1:0] mult [MaxElements];
    logic [IdxW-1:0]  pos;
    logic [DigitW-1:0] digit;
    nib_vec_t         pool_d;
    nib_vec_t         perm_d;
    logic [RankW-1:0] rank_d;

    // quotient by comparing the rank against multiples of (left-1)!
    always_comb begin
      active = len_q[i] > LenW'(i);
      left   = len_q[i] - LenW'(i);
      fsel   = active ? pufact_pkg::fact_f(left - LenW'(1)) : '0;
      mult[0] = '0;
      pos     = '0;
      for (int q = 1; q < MaxElements; q++) begin
        mult[q] = fsel * RankW'(q);
        if (active && (rank_q[i] >= mult[q]) && (LenW'(q) < left)) begin
          pos = pos + IdxW'(1);
        end
      end
      rank_d = rank_q[i] - mult[pos];
      digit  = pool_q[i][pos];
    end

    // take the digit out of the pool and place it in the result
    always_comb begin
      pool_d = pool_q[i];
      perm_d = perm_q[i];
      if (active) begin
        for (int j = 0; j < MaxElements; j++) begin
          if (IdxW'(j) >= pos) begin
            if (j + 1 < MaxElements) begin
              pool_d[j] = pool_q[i][j+1];
            end else begin
              pool_d[j] = '0;
            end
          end
        end
        if (!err_q[i]) begin
          perm_d[i] = digit;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (stg_rdy[i+1]) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (vld_q[i] && stg_rdy[i+1]) begin
        len_q[i+1]  <= len_q[i];
        rank_q[i+1] <= active ? rank_d : rank_q[i];
        err_q[i+1]  <= err_q[i];
        pool_q[i+1] <= pool_d;
        perm_q[i+1] <= perm_d;
      end
    end
  end

  // output beat from the last stage
  assign out_valid_o   = vld_q[MaxElements];
  assign rank_error_o  = err_q[MaxElements];
  assign perm_digits_o = err_q[MaxElements] ? '0 : perm_q[MaxElements];

endmodule

`default_nettype wire

/* tb/sv/perm_unrank_checker.sv */
// checker for the permutation unranking block: predicts each result and compares it
`timescale 1ns / 1ps

module perm_unrank_checker (
  input  wire logic                                                   clk_i,
  input  wire logic                                                   rst_ni,
  input  wire logic                                                   in_valid_i,
  input  wire logic                                                   in_ready_i,
  input  wire logic [pufact_pkg::LEN_W-1:0]                           perm_length_i,
  input  wire logic [pufact_pkg::RANK_W-1:0]                          rank_index_i,
  input  wire logic                                                   out_valid_i,
  input  wire logic                                                   out_ready_i,
  input  wire logic [pufact_pkg::DIGIT_W*pufact_pkg::MAX_ELEMENTS_DEF-1:0] perm_digits_i,
  input  wire logic                                                   rank_error_i,
  output int unsigned                                                 mismatches_o,
  output int unsigned                                                 outstanding_o
);

  localparam int unsigned LenW      = pufact_pkg::LEN_W;
  localparam int unsigned RankW     = pufact_pkg::RANK_W;
  localparam int unsigned DigitW    = pufact_pkg::DIGIT_W;
  localparam int unsigned MaxEl     = pufact_pkg::MAX_ELEMENTS_DEF;
  localparam int unsigned PermW     = DigitW * MaxEl;
  localparam int unsigned RingDepth = 256;

  typedef struct packed {
    logic [PermW-1:0] digits;
    logic             err;
  } perm_result_t;

  perm_result_t expected_ring [RingDepth];
  perm_result_t want;
  int unsigned  wr_cnt = 0;
  int unsigned  rd_cnt = 0;
  int unsigned  mismatch_count = 0;
  int unsigned  pending_beats = 0;

  assign mismatches_o  = mismatch_count;
  assign outstanding_o = pending_beats;

  // k-th lexicographic permutation of 1..n, split over factorial digits
  function automatic perm_result_t unrank_perm(input logic [LenW-1:0] len,
                                               input logic [RankW-1:0] rank);
    logic [DigitW-1:0] pool [MaxEl];
    int unsigned        left;
    int unsigned        rem;
    int unsigned        pos;
    int unsigned        fact_n;
    int unsigned        radix;
    perm_result_t       res;
    res = '0;
    // length out of range
    if (len == 0 || len > MaxEl) begin
      res.err = 1'b1;
      return res;
    end
    fact_n = 1;
    for (int m = 2; m <= len; m++) fact_n *= m;
    // rank zero or past n!
    if (rank == 0 || rank > fact_n) begin
      res.err = 1'b1;
      return res;
    end
    for (int i = 0; i < len; i++) pool[i] = DigitW'(i + 1);
    rem  = rank - 1;
    left = len;
    // pick one unused digit per position, remainder carries on
    for (int i = 0; i < len; i++) begin
      radix = 1;
      for (int m = 2; m < left; m++) radix *= m;
      pos = rem / radix;
      if (pos >= left) pos = left - 1;
      rem = rem % radix;
      res.digits[DigitW*i +: DigitW] = pool[pos];
      for (int j = pos; j + 1 < left; j++) pool[j] = pool[j+1];
      left--;
    end
    return res;
  endfunction

  // store a prediction per input beat, compare each output beat in order
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        expected_ring[wr_cnt % RingDepth] = unrank_perm(perm_length_i, rank_index_i);
        wr_cnt++;
      end
      if (out_valid_i && out_ready_i) begin
        if (wr_cnt == rd_cnt) begin
          mismatch_count++;
          $display("%0t: result beat with nothing expected: perm_digits %h rank_error %b",
                   $time, perm_digits_i, rank_error_i);
        end else begin
          want = expected_ring[rd_cnt % RingDepth];
          rd_cnt++;
          if (perm_digits_i !== want.digits) begin
            mismatch_count++;
            $display("%0t: perm_digits expected %h actual %h",
                     $time, want.digits, perm_digits_i);
          end
          if (rank_error_i !== want.err) begin
            mismatch_count++;
            $display("%0t: rank_error expected %b actual %b",
                     $time, want.err, rank_error_i);
          end
        end
      end
      pending_beats <= wr_cnt - rd_cnt;
    end
  end

endmodule

/* tb/sv/testbench.sv */
// top of the permutation unranking testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned LenW   = pufact_pkg::LEN_W;
  localparam int unsigned RankW  = pufact_pkg::RANK_W;
  localparam int unsigned PermW  = pufact_pkg::DIGIT_W * pufact_pkg::MAX_ELEMENTS_DEF;

  logic                                clk_i;
  logic                                rst_ni;
  logic                                in_valid;
  logic                                in_ready;
  logic [LenW-1:0]                     perm_length;
  logic [RankW-1:0]                    rank_index;
  logic                                out_valid;
  logic                                out_ready;
  logic [PermW-1:0]                    perm_digits;
  logic                                rank_error;
  int unsigned                         mismatches;
  int unsigned                         outstanding;
  int unsigned                         burst_left = 0;

  permutation_unrank_factoradic dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .perm_length_i (perm_length),
    .rank_index_i  (rank_index),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .perm_digits_o (perm_digits),
    .rank_error_o  (rank_error)
  );

  perm_unrank_checker checker_inst (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .perm_length_i (perm_length),
    .rank_index_i  (rank_index),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .perm_digits_i (perm_digits),
    .rank_error_i  (rank_error),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  // 10 ns clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // offer one beat, with a random gap whenever a burst runs out
  task automatic offer_rank(input logic [LenW-1:0] len, input logic [RankW-1:0] rank);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 50)
                                               : $urandom_range(1, 10);
    end
    burst_left--;
    in_valid    <= 1'b1;
    perm_length <= len;
    rank_index  <= rank;
    do @(posedge clk_i); while (!in_ready);
  endtask

  // reset, directed beats, random beats, then drain and verdict
  initial begin
    int unsigned pick;
    int unsigned len;
    int unsigned fact_n;
    rst_ni      = 1'b0;
    in_valid    = 1'b0;
    perm_length = '0;
    rank_index  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // identity, last permutation and the rejected cases
    offer_rank(4'd1, 19'd1);
    offer_rank(4'd1, 19'd2);
    offer_rank(4'd0, 19'd1);
    offer_rank(4'd15, 19'd524287);
    offer_rank(4'd10, 19'd1);
    offer_rank(4'd9, 19'd1);
    offer_rank(4'd9, 19'd362880);
    offer_rank(4'd9, 19'd362881);
    offer_rank(4'd9, 19'd0);
    offer_rank(4'd9, 19'd524287);
    offer_rank(4'd9, 19'd200000);
    offer_rank(4'd2, 19'd2);
    for (int k = 1; k <= 6; k++) offer_rank(4'd3, RankW'(k));
    offer_rank(4'd4, 19'd24);
    offer_rank(4'd4, 19'd25);
    offer_rank(4'd5, 19'd120);
    offer_rank(4'd6, 19'd721);
    offer_rank(4'd7, 19'd5040);
    offer_rank(4'd8, 19'd40320);

    // mostly legal ranks, with rejects and raw noise mixed in
    repeat (600) begin
      pick   = $urandom_range(0, 99);
      len    = $urandom_range(1, 9);
      fact_n = pufact_pkg::fact_f(LenW'(len));
      if (pick < 70) begin
        offer_rank(LenW'(len), RankW'($urandom_range(1, fact_n)));
      end else if (pick < 76) begin
        offer_rank(LenW'($urandom_range(0, 15)), '0);
      end else if (pick < 86) begin
        offer_rank(LenW'(len), RankW'($urandom_range(fact_n + 1, 524287)));
      end else if (pick < 90) begin
        offer_rank(($urandom_range(0, 1) == 0) ? LenW'(0) : LenW'($urandom_range(10, 15)),
                   RankW'($urandom_range(0, 524287)));
      end else if (pick < 95) begin
        offer_rank(LenW'(len), RankW'(fact_n + $urandom_range(0, 1)));
      end else begin
        offer_rank(LenW'($urandom_range(0, 15)), RankW'($urandom_range(0, 524287)));
      end
    end
    in_valid <= 1'b0;

    // drain the pipeline, then wait on before the verdict
    do @(posedge clk_i); while (outstanding != 0);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[permutation_unrank_factoradic] OK");
    end else begin
      $display("[permutation_unrank_factoradic] ERROR");
    end
    $finish;
  end

  // receiver: random stall patterns, plus long hold-offs that fill the pipeline
  initial begin
    int unsigned segment;
    int unsigned mode;
    out_ready = 1'b0;
    segment   = 0;
    do @(posedge clk_i); while (!rst_ni);
    forever begin
      segment++;
      if (segment == 6 || segment == 60) begin
        out_ready <= 1'b0;
        repeat (80) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 3);
        repeat ($urandom_range(1, 40)) begin
          case (mode)
            0: out_ready <= 1'b1;
            1: out_ready <= 1'($urandom_range(0, 1));
            2: out_ready <= ($urandom_range(0, 7) == 0);
            default: out_ready <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("[permutation_unrank_factoradic] ERROR");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/pufact_pkg.sv
rtl/core/permutation_unrank_factoradic.sv
tb/sv/perm_unrank_checker.sv
tb/sv/testbench.sv
